// ===== rtl/core/murmur_hash_64a_defines.svh =====
// Assertion macros shared by the murmur_hash_64a RTL.
`ifndef MURMUR_HASH_64A_DEFINES_SVH
`define MURMUR_HASH_64A_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, clocked on clk, off during reset
`define MH_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("murmur_hash_64a: assertion failed");
// next-cycle implication
`define MH_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("murmur_hash_64a: assertion failed");
`else
`define MH_ASSERT_IMP(label, ante, cons)
`define MH_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/mh64a_pkg.sv =====
// Constants and controller/datapath interface types for the MurmurHash64A core.
`default_nettype none
package mh64a_pkg;

	localparam logic [63:0] MUR_M    = 64'hc6a4a7935bd1e995;
	localparam int unsigned MUR_R    = 47;
	localparam logic [63:0] MUR_SEED = 64'h000000007fffffff;
	localparam int unsigned LEN_W    = 16;

	// multiplier operand select
	localparam logic [2:0] SRC_LEN   = 3'd0;
	localparam logic [2:0] SRC_WORD  = 3'd1;
	localparam logic [2:0] SRC_WMIX  = 3'd2;
	localparam logic [2:0] SRC_HXW   = 3'd3;
	localparam logic [2:0] SRC_HTAIL = 3'd4;
	localparam logic [2:0] SRC_HFIN  = 3'd5;

	// product write-back destination
	localparam logic [1:0] WB_NONE  = 2'd0;
	localparam logic [1:0] WB_HSEED = 2'd1;
	localparam logic [1:0] WB_W     = 2'd2;
	localparam logic [1:0] WB_H     = 2'd3;

	typedef struct packed {
		logic       load_word;
		logic       load_len;
		logic       issue;
		logic [2:0] mul_src;
		logic [1:0] wb_dst;
		logic       rem_sub8;
		logic       rem_clear;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic rem_zero;
		logic rem_ge8;
		logic rem_is8;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/mh64a_mul.sv =====
// Two-stage 64-bit multiplier by the constant M, low 64 bits of the product.
`default_nettype none
module mh64a_mul
	import mh64a_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        issue,
	input  wire logic [63:0] a,
	output logic [63:0]      prod
);

	localparam logic [31:0] M_LO = MUR_M[31:0];
	localparam logic [31:0] M_HI = MUR_M[63:32];

	logic [63:0] pll_s1;
	logic [31:0] pcl_s1;
	logic [31:0] pch_s1;

	// only the low 32 bits of the cross products reach the low 64 of the result
	always_ff @(posedge clk) begin
		if (issue) begin
			pll_s1 <= {32'b0, a[31:0]} * {32'b0, M_LO};
			pcl_s1 <= a[31:0] * M_HI;
			pch_s1 <= a[63:32] * M_LO;
		end
	end

	assign prod = pll_s1 + {pcl_s1 + pch_s1, 32'b0};

endmodule
`default_nettype wire

// ===== rtl/core/mh64a_dp.sv =====
// Datapath: hash, word and byte-count registers, operand mux, output register.
`default_nettype none
module mh64a_dp
	import mh64a_pkg::*;
#(
	parameter longint unsigned MAX_KEY_BYTES = 65535
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dp_cmd_t          cmd,
	input  wire logic [63:0]      key_word,
	input  wire logic [LEN_W-1:0] key_length,
	output dp_status_t            sts,
	output logic [63:0]           hash_value
);

	localparam logic [LEN_W-1:0] LenCap =
		(MAX_KEY_BYTES > 64'd65535) ? 16'hffff : 16'(MAX_KEY_BYTES);

	logic [63:0]      h_q;
	logic [63:0]      w_q;
	logic [LEN_W-1:0] rem_q;
	logic [63:0]      hash_q;
	logic [63:0]      tail_mask;
	logic [63:0]      operand;
	logic [63:0]      prod;
	logic [LEN_W-1:0] len_sat;

	assign len_sat = (key_length > LenCap) ? LenCap : key_length;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			tail_mask[8*i +: 8] = (3'(i) < rem_q[2:0]) ? 8'hff : 8'h00;
		end
	end

	always_comb begin
		case (cmd.mul_src)
			SRC_LEN:   operand = {48'b0, rem_q};
			SRC_WORD:  operand = w_q;
			SRC_WMIX:  operand = w_q ^ (w_q >> MUR_R);
			SRC_HXW:   operand = h_q ^ w_q;
			SRC_HTAIL: operand = h_q ^ (w_q & tail_mask);
			SRC_HFIN:  operand = h_q ^ (h_q >> MUR_R);
			default:   operand = w_q;
		endcase
	end

	mh64a_mul u_mul (
		.clk   (clk),
		.issue (cmd.issue),
		.a     (operand),
		.prod  (prod)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			w_q <= key_word;
		end else if (cmd.wb_dst == WB_W) begin
			w_q <= prod;
		end
		if (cmd.wb_dst == WB_HSEED) begin
			h_q <= MUR_SEED ^ prod;
		end else if (cmd.wb_dst == WB_H) begin
			h_q <= prod;
		end
		if (cmd.load_out) begin
			hash_q <= prod ^ (prod >> MUR_R);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (cmd.load_len) begin
			rem_q <= len_sat;
		end else if (cmd.rem_sub8) begin
			rem_q <= rem_q - LEN_W'(8);
		end else if (cmd.rem_clear) begin
			rem_q <= '0;
		end
	end

	assign sts.rem_zero = (rem_q == '0);
	assign sts.rem_ge8  = |rem_q[LEN_W-1:3];
	assign sts.rem_is8  = (rem_q == LEN_W'(8));
	assign hash_value   = hash_q;

endmodule
`default_nettype wire

// ===== rtl/core/mh64a_ctrl.sv =====
// Controller: sequences seed, word mix, tail and finalization on the shared multiplier.
`default_nettype none
module mh64a_ctrl
	import mh64a_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t sts,
	output dp_cmd_t         cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SEED_M = 4'd1;
	localparam logic [3:0] S_SEED_W = 4'd2;
	localparam logic [3:0] S_W1_M   = 4'd3;
	localparam logic [3:0] S_W1_W   = 4'd4;
	localparam logic [3:0] S_W2_M   = 4'd5;
	localparam logic [3:0] S_W2_W   = 4'd6;
	localparam logic [3:0] S_W3_M   = 4'd7;
	localparam logic [3:0] S_W3_W   = 4'd8;
	localparam logic [3:0] S_T_M    = 4'd9;
	localparam logic [3:0] S_T_W    = 4'd10;
	localparam logic [3:0] S_F_M    = 4'd11;
	localparam logic [3:0] S_F_W    = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [3:0] dispatch;
	logic       inside_q;
	logic       out_valid_q;

	// where a word goes once the remaining count is known
	assign dispatch = sts.rem_ge8 ? S_W1_M : (!sts.rem_zero ? S_T_M : S_F_M);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_word = 1'b1;
					if (!inside_q) begin
						cmd.load_len = 1'b1;
						state_d      = S_SEED_M;
					end else begin
						state_d = dispatch;
					end
				end
			end
			S_SEED_M: begin
				cmd.issue   = 1'b1;
				cmd.mul_src = SRC_LEN;
				state_d     = S_SEED_W;
			end
			S_SEED_W: begin
				cmd.wb_dst = WB_HSEED;
				state_d    = dispatch;
			end
			S_W1_M: begin
				cmd.issue   = 1'b1;
				cmd.mul_src = SRC_WORD;
				state_d     = S_W1_W;
			end
			S_W1_W: begin
				cmd.wb_dst = WB_W;
				state_d    = S_W2_M;
			end
			S_W2_M: begin
				cmd.issue   = 1'b1;
				cmd.mul_src = SRC_WMIX;
				state_d     = S_W2_W;
			end
			S_W2_W: begin
				cmd.wb_dst = WB_W;
				state_d    = S_W3_M;
			end
			S_W3_M: begin
				cmd.issue   = 1'b1;
				cmd.mul_src = SRC_HXW;
				state_d     = S_W3_W;
			end
			S_W3_W: begin
				cmd.wb_dst   = WB_H;
				cmd.rem_sub8 = 1'b1;
				state_d      = sts.rem_is8 ? S_F_M : S_IDLE;
			end
			S_T_M: begin
				cmd.issue   = 1'b1;
				cmd.mul_src = SRC_HTAIL;
				state_d     = S_T_W;
			end
			S_T_W: begin
				cmd.wb_dst    = WB_H;
				cmd.rem_clear = 1'b1;
				state_d       = S_F_M;
			end
			S_F_M: begin
				cmd.issue   = 1'b1;
				cmd.mul_src = SRC_HFIN;
				state_d     = S_F_W;
			end
			S_F_W: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out  = 1'b1;
					cmd.rem_clear = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_len) begin
				inside_q <= 1'b1;
			end else if (cmd.load_out) begin
				inside_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/murmur_hash_64a.sv =====
// Top level of the streaming MurmurHash64A core (seed 0x7fffffff).
`default_nettype none
`include "murmur_hash_64a_defines.svh"
// MurmurHash64A of a byte key, fed as little-endian 64-bit words on the input
// channel (first key byte in key_word[7:0]). key_length is sampled on the first
// word of each key only and is capped at MAX_KEY_BYTES; a key of length zero
// still takes one transfer, whose word is ignored. Bytes past the key's end in
// the last word are ignored. One hash_value transfer follows the key's last word.
// Sequencing: every 64-bit multiply by M runs on one shared two-stage multiplier
// (issue cycle, write-back cycle), and the controller steps through them in
// order, one word at a time. After an input transfer, the first word of a key
// adds seeding (one multiply), a full word adds three multiplies, a 1..7 byte
// tail adds one, and finalization adds one more before the result lands in the
// output register. The result register lets the next key's words come in while
// a hash is still waiting to be taken; finalization stalls only if a second hash
// is ready before the first one has been transferred.
module murmur_hash_64a
	import mh64a_pkg::*;
#(
	parameter longint unsigned MAX_KEY_BYTES = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] key_word,
	input  wire logic [15:0] key_length,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      hash_value
);

	dp_cmd_t    cmd;
	dp_status_t sts;

	// sequencing of seed / word / tail / finalization steps
	mh64a_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hash state, byte counter, shared multiplier and result register
	mh64a_dp #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.key_word   (key_word),
		.key_length (key_length),
		.sts        (sts),
		.hash_value (hash_value)
	);

	// one word at a time: the block is busy right after each input transfer
	`MH_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready)
	// a pending result is never overwritten
	`MH_ASSERT_IMP(a_no_out_overwrite, cmd.load_out, !out_valid || out_ready)
	// the multiplier is never issued in its own write-back cycle
	`MH_ASSERT_IMP(a_issue_no_wb, cmd.issue, cmd.wb_dst == WB_NONE)
	// a full word is only mixed when at least eight bytes remain
	`MH_ASSERT_IMP(a_sub8_needs_bytes, cmd.rem_sub8, sts.rem_ge8)

endmodule
`default_nettype wire

// ===== tb/murmur_hash_64a_tb.sv =====
// Self-checking testbench for murmur_hash_64a: directed keys, then random keys.
`timescale 1ns / 100ps

module murmur_hash_64a_tb;

	// hash constants
	localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
	localparam int unsigned MIX_SHIFT = 47;
	localparam logic [63:0] MIX_SEED  = 64'h000000007fffffff;
	localparam logic [63:0] KEY_LIMIT = 64'd65535;   // block's MAX_KEY_BYTES default

	localparam int unsigned RANDOM_BEATS   = 500;   // word transfers in the random part
	localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles without any transfer
	localparam int unsigned DRAIN_CYCLES   = 30;    // extra cycles after the last expected hash

	typedef struct packed {
		logic [63:0] word;
		logic [15:0] len;
	} key_beat_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic [63:0] key_word   = '0;
	logic [15:0] key_length = '0;
	logic        out_ready  = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [63:0] hash_value;

	// predictor state
	logic [63:0] hash_acc   = '0;
	logic [16:0] bytes_left = '0;
	logic        mid_key    = 1'b0;

	logic [63:0] pending_hashes[$];
	logic [63:0] new_hash;
	logic [63:0] want_hash;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned beats_sent     = 0;
	int unsigned idle_cycles    = 0;
	int unsigned error_count    = 0;

	// Directed keys. Length on a first word starts a key; on later words it must be ignored.
	key_beat_t directed_beats [17] = '{
		'{64'hffff_ffff_ffff_ffff, 16'd0},      // empty key, word ignored
		'{64'h0000_0000_0000_0000, 16'd0},      // empty key, all-zero word
		'{64'hffff_ffff_ffff_ffff, 16'd1},      // one-byte tail
		'{64'h0123_4567_89ab_cdef, 16'd7},      // seven-byte tail
		'{64'hffff_ffff_ffff_ffff, 16'd8},      // whole final word
		'{64'h0000_0000_0000_0000, 16'd8},
		'{64'h8000_0000_0000_0001, 16'd9},      // full word ...
		'{64'hffff_ffff_ffff_ffff, 16'hffff},   // ... then 1-byte tail, length ignored
		'{64'hdead_beef_0bad_f00d, 16'd16},
		'{64'h5555_5555_5555_5555, 16'hffff},   // whole final word after a full one
		'{64'haaaa_aaaa_aaaa_aaaa, 16'd15},
		'{64'h0000_0000_0000_0000, 16'd0},      // 7-byte tail, zero length ignored
		'{64'h0000_0000_0000_0001, 16'd24},     // three full words
		'{64'h0000_0000_0000_0002, 16'd0},
		'{64'h0000_0000_0000_0003, 16'd0},
		'{64'hffff_ffff_ffff_ffff, 16'd0},      // empty key right after a long one
		'{64'h7fff_ffff_ffff_ffff, 16'd2}
	};

	murmur_hash_64a u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.key_word   (key_word),
		.key_length (key_length),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

	always #6 clk = ~clk;

	// Predictor: absorbs one word, returns 1 with the digest when the key ends.
	function automatic bit absorb_word(input logic [63:0] w, input logic [15:0] len,
			output logic [63:0] digest);
		logic [63:0] h;
		logic [63:0] k;
		logic [63:0] mask;
		if (!mid_key) begin
			h = {48'd0, len};
			if (h > KEY_LIMIT)
				h = KEY_LIMIT;
			bytes_left = h[16:0];
			hash_acc   = MIX_SEED ^ (h * MIX_MUL);
			mid_key    = 1'b1;
		end
		h = hash_acc;
		digest = '0;
		if (bytes_left >= 17'd8) begin
			k = w * MIX_MUL;
			k = k ^ (k >> MIX_SHIFT);
			k = k * MIX_MUL;
			h = (h ^ k) * MIX_MUL;
			bytes_left = bytes_left - 17'd8;
			if (bytes_left != 17'd0) begin
				hash_acc = h;
				return 1'b0;
			end
		end else if (bytes_left != 17'd0) begin
			// partial tail: only the key's own low bytes count
			mask = (64'd1 << (8 * bytes_left)) - 64'd1;
			h = (h ^ (w & mask)) * MIX_MUL;
		end
		h = h ^ (h >> MIX_SHIFT);
		h = h * MIX_MUL;
		h = h ^ (h >> MIX_SHIFT);
		digest     = h;
		hash_acc   = '0;
		bytes_left = '0;
		mid_key    = 1'b0;
		return 1'b1;
	endfunction

	// Mostly random words, with the extremes now and then.
	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 15))
			0: return 64'h0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// One word transfer with an optional random gap in front.
	task automatic send_beat(input logic [63:0] w, input logic [15:0] len);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		key_word   <= w;
		key_length <= len;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
	endtask

	// Whole key: first word carries the length, later words carry junk in key_length.
	task automatic send_key(input int unsigned len);
		int unsigned beats;
		beats = (len == 0) ? 1 : (len + 7) / 8;
		for (int unsigned i = 0; i < beats; i++)
			send_beat(rand_word(), (i == 0) ? len[15:0] : 16'($urandom));
	endtask

	// Receiver: per-cycle random stall.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Monitor: predict on input transfers, compare on output transfers, watch for hangs.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (absorb_word(key_word, key_length, new_hash))
					pending_hashes.push_back(new_hash);
			end
			if (out_valid && out_ready) begin
				if (pending_hashes.size() == 0) begin
					$error("hash_value: expected no transfer, actual %h", hash_value);
					error_count++;
				end else begin
					want_hash = pending_hashes.pop_front();
					if (hash_value !== want_hash) begin
						$error("hash_value: expected %h, actual %h", want_hash, hash_value);
						error_count++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int unsigned key_len;
		int unsigned phase_target;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// three idling profiles: slow receiver, slow sender, full rate
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 30;
					recv_stall_pct = 83;
				end
				1: begin
					send_idle_pct  = 83;
					recv_stall_pct = 30;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase

			if (phase == 0) begin
				foreach (directed_beats[i])
					send_beat(directed_beats[i].word, directed_beats[i].len);
			end

			phase_target = beats_sent + RANDOM_BEATS / 3;
			while (beats_sent < phase_target) begin
				case ($urandom_range(0, 9))
					0:          key_len = 0;
					1, 2, 3, 4: key_len = $urandom_range(1, 24);
					5, 6:       key_len = 8 * $urandom_range(1, 6);
					7, 8:       key_len = $urandom_range(25, 120);
					default:    key_len = $urandom_range(121, 400);
				endcase
				send_key(key_len);
			end
		end
		in_valid <= 1'b0;

		// let the monitor see the last transfer, then drain
		@(posedge clk);
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mh64a_pkg.sv
rtl/core/mh64a_mul.sv
rtl/core/mh64a_dp.sv
rtl/core/mh64a_ctrl.sv
rtl/core/murmur_hash_64a.sv
tb/murmur_hash_64a_tb.sv
